@@ design/mstt_pkg.sv @@
package mstt_pkg;

	typedef enum logic [1:0] {
		FUNC_CREATE  = 2'd0,
		FUNC_DELETE  = 2'd1,
		FUNC_QUERY   = 2'd2,
		FUNC_SERVICE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		RES_CREATE  = 3'd0,
		RES_DELETE  = 3'd1,
		RES_QUERY   = 3'd2,
		RES_EXPIRY  = 3'd3,
		RES_SVC_END = 3'd4
	} res_kind_t;

	localparam logic [1:0] KIND_MS_REPEAT  = 2'd1;
	localparam logic [1:0] KIND_SEC_REPEAT = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  timer_kind;
		logic [15:0] timeout;
		logic [15:0] owner_id;
		logic [15:0] tick_now;
		logic [15:0] second_now;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic        ok;
		logic [15:0] fired_id;
		logic [3:0]  fired_slot;
		logic        last;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_DONE = 2'd2
	} state_t;

	function automatic logic ms_window(logic [15:0] lo, logic [15:0] hi, logic [15:0] s);
		logic r;
		if (lo < hi) r = (lo < s) && (s <= hi);
		else if (lo > hi) r = (lo < s) || (s <= hi);
		else r = 1'b0;
		return r;
	endfunction

endpackage

@@ design/multi_slot_timer_table.sv @@
// Timer slot table: create, delete, query and service commands enter a two-entry queue and are
// carried out by a sequencer that walks one slot per cycle (create and delete stop at the slot
// they hit); service emits one transfer per expiry plus an end marker, and a stalled output holds
// the walk at the current slot.
module multi_slot_timer_table #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,   // func
	input  logic [71:0] s_axis_tdata,   // timer_kind, timeout, owner_id, tick_now, second_now, pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [2:0]  m_axis_tuser,   // result_kind
	output logic [23:0] m_axis_tdata,   // ok, fired_id, fired_slot, pad
	output logic        m_axis_tlast
);
	import mstt_pkg::*;

	cmd_t in_cmd, q_cmd;
	res_t res;
	logic q_valid, q_ready;

	assign in_cmd.func       = s_axis_tuser;
	assign in_cmd.timer_kind = s_axis_tdata[1:0];
	assign in_cmd.timeout    = s_axis_tdata[17:2];
	assign in_cmd.owner_id   = s_axis_tdata[33:18];
	assign in_cmd.tick_now   = s_axis_tdata[49:34];
	assign in_cmd.second_now = s_axis_tdata[65:50];

	mstt_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	mstt_back #(.SLOTS(SLOTS)) u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_cmd,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign m_axis_tuser = res.result_kind;
	assign m_axis_tdata = {3'd0, res.fired_slot, res.fired_id, res.ok};
	assign m_axis_tlast = res.last;

	logic unused_pad;
	assign unused_pad = ^s_axis_tdata[71:66];
endmodule

@@ design/mstt_front.sv @@
module mstt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mstt_pkg::cmd_t     in_cmd,
	output logic               q_valid,
	input  logic               q_ready,
	output mstt_pkg::cmd_t     q_cmd
);
	import mstt_pkg::*;

	// two-entry command queue
	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_cmd;
	end

	assign q_cmd = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ design/mstt_back.sv @@
module mstt_back #(
	parameter int SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  mstt_pkg::cmd_t     q_cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output mstt_pkg::res_t     out_res
);
	import mstt_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOTS-1:0] valid_q;
	logic [1:0]  kind_q   [SLOTS];
	logic [15:0] period_q [SLOTS];
	logic [15:0] stop_q   [SLOTS];
	logic [15:0] owner_q  [SLOTS];
	logic [15:0] prev_tick_q;

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [IW-1:0] idx_q;
	logic   found_q;
	res_t   res_q;
	logic   res_v_q;

	logic   free_room;
	logic   last_idx;
	logic   s_valid;
	logic   s_fire;
	logic   owner_hit;
	logic   emit_ok;
	logic   emit_now;

	assign free_room = !res_v_q || out_ready;
	assign out_valid = res_v_q;
	assign out_res   = res_q;
	assign last_idx  = (idx_q == IW'(SLOTS - 1));
	assign s_valid   = valid_q[idx_q];
	assign owner_hit = s_valid && (owner_q[idx_q] == cmd_q.owner_id);

	always_comb begin
		if (kind_q[idx_q][1]) s_fire = s_valid && (stop_q[idx_q] == cmd_q.second_now);
		else s_fire = s_valid && ms_window(prev_tick_q, cmd_q.tick_now, stop_q[idx_q]);
	end

	// in scan, each step, and so any create, delete or expiry result, needs the output slot free
	assign emit_ok = free_room;

	always_comb begin
		emit_now = 1'b0;
		if (state_q == ST_SCAN && emit_ok) begin
			if (cmd_q.func == FUNC_CREATE && !s_valid) emit_now = 1'b1;
			else if (cmd_q.func == FUNC_DELETE && owner_hit) emit_now = 1'b1;
			else if (cmd_q.func == FUNC_SERVICE && s_fire) emit_now = 1'b1;
		end
		if (state_q == ST_DONE && free_room) emit_now = 1'b1;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_SCAN;
			ST_SCAN: begin
				if (emit_ok) begin
					if (cmd_q.func == FUNC_CREATE && !s_valid) state_d = ST_IDLE;
					else if (cmd_q.func == FUNC_DELETE && owner_hit) state_d = ST_IDLE;
					else if (last_idx) state_d = ST_DONE;
				end
			end
			ST_DONE: if (free_room) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign q_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) cmd_q <= q_cmd;
		if (state_q == ST_SCAN && emit_ok) begin
			if (cmd_q.func == FUNC_CREATE && !s_valid) begin
				kind_q[idx_q]   <= cmd_q.timer_kind;
				period_q[idx_q] <= cmd_q.timeout;
				owner_q[idx_q]  <= cmd_q.owner_id;
				stop_q[idx_q]   <= cmd_q.timeout +
					(cmd_q.timer_kind[1] ? cmd_q.second_now : cmd_q.tick_now);
			end
			if (cmd_q.func == FUNC_SERVICE && s_fire) begin
				if (kind_q[idx_q] == KIND_MS_REPEAT)
					stop_q[idx_q] <= period_q[idx_q] + cmd_q.tick_now;
				else if (kind_q[idx_q] == KIND_SEC_REPEAT)
					stop_q[idx_q] <= period_q[idx_q] + cmd_q.second_now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			prev_tick_q <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			res_v_q     <= 1'b0;
			res_q       <= '0;
		end else begin
			state_q <= state_d;
			res_v_q <= emit_now || (res_v_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					idx_q   <= '0;
					found_q <= 1'b0;
				end
				ST_SCAN: begin
					if (emit_ok) begin
						idx_q <= idx_q + IW'(1);
						case (cmd_q.func)
							FUNC_CREATE: if (!s_valid) begin
								valid_q[idx_q] <= 1'b1;
								found_q <= 1'b1;
								res_q   <= '{RES_CREATE, 1'b1, 16'd0, 4'(idx_q), 1'b1};
							end
							FUNC_DELETE: if (owner_hit) begin
								valid_q[idx_q] <= 1'b0;
								found_q <= 1'b1;
								res_q   <= '{RES_DELETE, 1'b1, 16'd0, 4'(idx_q), 1'b1};
							end
							FUNC_QUERY: if (owner_hit) found_q <= 1'b1;
							FUNC_SERVICE: if (s_fire) begin
								if (!kind_q[idx_q][0]) valid_q[idx_q] <= 1'b0;
								res_q   <= '{RES_EXPIRY, 1'b1, owner_q[idx_q], 4'(idx_q), 1'b0};
							end
							default: ;
						endcase
					end
				end
				ST_DONE: begin
					if (free_room) begin
						case (cmd_q.func)
							FUNC_CREATE: res_q <= '{RES_CREATE, 1'b0, 16'd0, 4'd0, 1'b1};
							FUNC_DELETE: res_q <= '{RES_DELETE, 1'b0, 16'd0, 4'd0, 1'b1};
							FUNC_QUERY:  res_q <= '{RES_QUERY, found_q, 16'd0, 4'd0, 1'b1};
							default: begin
								res_q       <= '{RES_SVC_END, 1'b0, 16'd0, 4'd0, 1'b1};
								prev_tick_q <= cmd_q.tick_now;
							end
						endcase
					end
				end
				default: ;
			endcase
		end
	end
endmodule

@@ verif/tb_multi_slot_timer_table.sv @@
module tb_multi_slot_timer_table;
	timeunit 1ns;
	timeprecision 1ps;
	import mstt_pkg::*;

	localparam int NSLOT = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [1:0]  s_axis_tuser;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [2:0]  m_axis_tuser;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;

	multi_slot_timer_table #(.SLOTS(NSLOT)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	// shadow timer table
	logic        tbl_valid [NSLOT];
	logic [1:0]  tbl_kind [NSLOT];
	logic [15:0] tbl_period [NSLOT];
	logic [15:0] tbl_stop [NSLOT];
	logic [15:0] tbl_owner [NSLOT];
	logic [15:0] prev_ms_tick;

	res_t pending_results[$];
	int   send_idle_pct;
	int   recv_idle_pct;
	int   idle_cycles;
	bit   failed;
	bit   done;

	// shared clock counters for stimulus
	logic [15:0] ms_clock;
	logic [15:0] sec_clock;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic in_ms_window(logic [15:0] lo, logic [15:0] hi, logic [15:0] s);
		if (lo < hi) return (s > lo) && (s <= hi);
		if (lo > hi) return (s > lo) || (s <= hi);
		return 1'b0;
	endfunction

	function automatic res_t make_res(res_kind_t k, logic ok, logic [15:0] id,
			logic [3:0] slot, logic lst);
		res_t r;
		r.result_kind = k;
		r.ok = ok;
		r.fired_id = id;
		r.fired_slot = slot;
		r.last = lst;
		return r;
	endfunction

	task automatic predict_timer_op(cmd_t c);
		int i;
		bit hit;
		logic [15:0] now;
		hit = 0;
		case (func_t'(c.func))
			FUNC_CREATE: begin
				now = c.timer_kind[1] ? c.second_now : c.tick_now;
				for (i = 0; i < NSLOT && !hit; i++) begin
					if (!tbl_valid[i]) begin
						hit = 1;
						tbl_valid[i] = 1'b1;
						tbl_kind[i] = c.timer_kind;
						tbl_period[i] = c.timeout;
						tbl_owner[i] = c.owner_id;
						tbl_stop[i] = c.timeout + now;
						pending_results.push_back(make_res(RES_CREATE, 1'b1, 16'd0, i[3:0], 1'b1));
					end
				end
				if (!hit) pending_results.push_back(make_res(RES_CREATE, 1'b0, 16'd0, 4'd0, 1'b1));
			end
			FUNC_DELETE: begin
				for (i = 0; i < NSLOT && !hit; i++) begin
					if (tbl_valid[i] && tbl_owner[i] == c.owner_id) begin
						hit = 1;
						tbl_valid[i] = 1'b0;
						pending_results.push_back(make_res(RES_DELETE, 1'b1, 16'd0, i[3:0], 1'b1));
					end
				end
				if (!hit) pending_results.push_back(make_res(RES_DELETE, 1'b0, 16'd0, 4'd0, 1'b1));
			end
			FUNC_QUERY: begin
				for (i = 0; i < NSLOT; i++)
					if (tbl_valid[i] && tbl_owner[i] == c.owner_id) hit = 1;
				pending_results.push_back(make_res(RES_QUERY, hit, 16'd0, 4'd0, 1'b1));
			end
			default: begin
				for (i = 0; i < NSLOT; i++) begin
					if (tbl_valid[i]) begin
						if (tbl_kind[i][1]) hit = (tbl_stop[i] == c.second_now);
						else hit = in_ms_window(prev_ms_tick, c.tick_now, tbl_stop[i]);
						if (hit) begin
							pending_results.push_back(make_res(RES_EXPIRY, 1'b1, tbl_owner[i],
								i[3:0], 1'b0));
							if (tbl_kind[i] == KIND_MS_REPEAT)
								tbl_stop[i] = tbl_period[i] + c.tick_now;
							else if (tbl_kind[i] == KIND_SEC_REPEAT)
								tbl_stop[i] = tbl_period[i] + c.second_now;
							else
								tbl_valid[i] = 1'b0;
						end
					end
				end
				pending_results.push_back(make_res(RES_SVC_END, 1'b0, 16'd0, 4'd0, 1'b1));
				prev_ms_tick = c.tick_now;
			end
		endcase
	endtask

	task automatic send_cmd(func_t f, logic [1:0] k, logic [15:0] tmo, logic [15:0] id,
			logic [15:0] tk, logic [15:0] sc);
		cmd_t c;
		c.func = f;
		c.timer_kind = k;
		c.timeout = tmo;
		c.owner_id = id;
		c.tick_now = tk;
		c.second_now = sc;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= c.func;
		s_axis_tdata <= {8'd0, sc, tk, id, tmo, k};
		do @(posedge clk); while (!s_axis_tready);
		predict_timer_op(c);
	endtask

	// receiver with random backpressure and result check
	always @(posedge clk) begin
		res_t got;
		res_t exp_r;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = make_res(res_kind_t'(m_axis_tuser), m_axis_tdata[0], m_axis_tdata[16:1],
					m_axis_tdata[20:17], m_axis_tlast);
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, got);
					failed = 1;
				end else begin
					exp_r = pending_results.pop_front();
					if (got.result_kind != exp_r.result_kind)
						$display("%0t: result_kind expected %0d actual %0d", $time,
							exp_r.result_kind, got.result_kind);
					if (got.ok != exp_r.ok)
						$display("%0t: ok expected %0d actual %0d", $time, exp_r.ok, got.ok);
					if (got.fired_id != exp_r.fired_id)
						$display("%0t: fired_id expected %0h actual %0h", $time,
							exp_r.fired_id, got.fired_id);
					if (got.fired_slot != exp_r.fired_slot)
						$display("%0t: fired_slot expected %0d actual %0d", $time,
							exp_r.fired_slot, got.fired_slot);
					if (got.last != exp_r.last)
						$display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
					if (got != exp_r) failed = 1;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on stalled traffic
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_multi_slot_timer_table: FAIL");
			$finish;
		end
	end

	task automatic tick_service(int ms_step, int sec_step);
		ms_clock = ms_clock + ms_step[15:0];
		sec_clock = sec_clock + sec_step[15:0];
		send_cmd(FUNC_SERVICE, 2'($urandom_range(3)), 16'($urandom), 16'($urandom),
			ms_clock, sec_clock);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic test_table_full();
		int i;
		for (i = 0; i < NSLOT; i++)
			send_cmd(FUNC_CREATE, i[1:0], (i == 0) ? 16'hffff : 16'd0,
				(i == 1) ? 16'hffff : i[15:0], 16'hffff, 16'hffff);
		send_cmd(FUNC_CREATE, 2'd0, 16'd5, 16'h1234, ms_clock, sec_clock);
		send_cmd(FUNC_QUERY, 2'd0, 16'd0, 16'h0000, 16'd0, 16'd0);
		send_cmd(FUNC_QUERY, 2'd0, 16'd0, 16'h5555, 16'd0, 16'd0);
		send_cmd(FUNC_DELETE, 2'd0, 16'd0, 16'h5555, 16'd0, 16'd0);
		send_cmd(FUNC_DELETE, 2'd0, 16'd0, 16'h0000, 16'd0, 16'd0);
		send_cmd(FUNC_CREATE, 2'd1, 16'd3, 16'd2, 16'd0, 16'd0);
		send_cmd(FUNC_DELETE, 2'd0, 16'd0, 16'd2, 16'd0, 16'd0);
	endtask

	task automatic test_service_edges();
		// unchanged tick, then a big jump, then a wrap, then a step back by one
		send_cmd(FUNC_SERVICE, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_cmd(FUNC_SERVICE, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_cmd(FUNC_SERVICE, 2'd0, 16'd0, 16'd0, 16'hfffe, 16'hffff);
		send_cmd(FUNC_SERVICE, 2'd0, 16'd0, 16'd0, 16'd4, 16'd1);
		send_cmd(FUNC_SERVICE, 2'd0, 16'd0, 16'd0, 16'd3, 16'd2);
		ms_clock = 16'd3;
		sec_clock = 16'd2;
	endtask

	task automatic test_random_mix(int n);
		int i;
		int r;
		logic [15:0] id;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
			if (r < 35)
				send_cmd(FUNC_CREATE, 2'($urandom_range(3)),
					($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12)), id,
					ms_clock, sec_clock);
			else if (r < 50)
				send_cmd(FUNC_DELETE, 2'($urandom_range(3)), 16'($urandom), id,
					16'($urandom), 16'($urandom));
			else if (r < 60)
				send_cmd(FUNC_QUERY, 2'($urandom_range(3)), 16'($urandom), id,
					16'($urandom), 16'($urandom));
			else if (r < 97)
				tick_service($urandom_range(4), $urandom_range(1));
			else
				tick_service($urandom, $urandom);
		end
	endtask

	initial begin
		failed = 0;
		done = 0;
		idle_cycles = 0;
		ms_clock = 0;
		sec_clock = 0;
		send_idle_pct = 34;
		recv_idle_pct = 78;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = '0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
		prev_ms_tick = 16'd0;
		@(posedge clk);
		test_service_edges();
		test_table_full();
		test_random_mix(90);
		send_idle_pct = 78;
		recv_idle_pct = 34;
		test_random_mix(100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(100);
		wait_drained();
		done = 1;
		if (!failed)
			$display("tb_multi_slot_timer_table: PASS");
		else
			$display("tb_multi_slot_timer_table: FAIL");
		$finish;
	end
endmodule
